>>> rtl/assert_macros.svh
// Assertion macros shared by the filter's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, clocked on clk and disabled in reset.
`define KTAF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, clocked on clk and disabled in reset.
`define KTAF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/ktaf_pkg.sv
// Package with types, constants and helpers for the Kalman tilt filter.
package ktaf_pkg;
	localparam int unsigned NUM_AXES_DEF = 2;
	localparam int unsigned IDX_W = 2;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned NUM_W = 62;

	localparam logic [31:0] DT_RST = 32'd5368709;
	localparam logic [31:0] QA_RST = 32'd1073742;
	localparam logic [31:0] QG_RST = 32'd3221225;
	localparam logic [31:0] R_RST = 32'd536870912;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	typedef enum logic [IDX_W-1:0] {
		REG_DT = 2'd0,
		REG_QA = 2'd1,
		REG_QG = 2'd2,
		REG_R = 2'd3
	} ktaf_reg_t;

	// Multiply operations, in the order the sequencer issues them.
	typedef enum logic [3:0] {
		OP_ANG = 4'd0,
		OP_P00 = 4'd1,
		OP_P01 = 4'd2,
		OP_QG = 4'd3,
		OP_C00 = 4'd4,
		OP_C01 = 4'd5,
		OP_C10 = 4'd6,
		OP_C11 = 4'd7,
		OP_ANGC = 4'd8,
		OP_BIASC = 4'd9
	} ktaf_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic pre;
		logic mul_en;
		logic wb_en;
		ktaf_op_t op;
		logic setup;
		logic div_start;
		logic finish;
	} ktaf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
	} ktaf_sts_t;

	// Sign extension of a 32-bit value to the working width.
	function automatic logic signed [39:0] sx(input logic [31:0] x);
		sx = {{8{x[31]}}, x};
	endfunction

	// Saturation of a working value to signed 32 bits.
	function automatic logic [31:0] sat32(input logic signed [39:0] x);
		if (x > 40'sd2147483647) begin
			sat32 = 32'h7fff_ffff;
		end else if (x < -40'sd2147483648) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction
endpackage

>>> rtl/ktaf_if.sv
// Valid/ready channel interfaces for samples and results.
interface ktaf_in_if;
	logic valid;
	logic ready;
	logic axis;
	logic signed [31:0] accel_angle;
	logic signed [31:0] gyro_rate;
	modport source (output valid, output axis, output accel_angle, output gyro_rate,
		input ready);
	modport sink (input valid, input axis, input accel_angle, input gyro_rate,
		output ready);
endinterface

interface ktaf_out_if;
	logic valid;
	logic ready;
	logic axis_out;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] corrected_rate;
	logic signed [31:0] gyro_bias;
	modport source (output valid, output axis_out, output filtered_angle,
		output corrected_rate, output gyro_bias, input ready);
	modport sink (input valid, input axis_out, input filtered_angle,
		input corrected_rate, input gyro_bias, output ready);
endinterface

>>> rtl/ktaf_div.sv
// Radix-2 restoring divider producing both gains from one shared divisor.
`include "assert_macros.svh"
module ktaf_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [ktaf_pkg::NUM_W-1:0] num0,
	input logic [ktaf_pkg::NUM_W-1:0] num1,
	input logic neg0,
	input logic neg1,
	input logic [32:0] den,
	output logic done,
	output logic [31:0] q0,
	output logic [31:0] q1
);
	import ktaf_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] rem0_q, rem1_q;
	logic [NUM_W-1:0] quo0_q, quo1_q;
	logic [32:0] den_q;
	logic neg0_q, neg1_q;
	logic [33:0] t0, t1;
	logic ge0, ge1;

	// One quotient bit per cycle for each numerator.
	assign t0 = {rem0_q, quo0_q[NUM_W-1]};
	assign t1 = {rem1_q, quo1_q[NUM_W-1]};
	assign ge0 = t0 >= {1'b0, den_q};
	assign ge1 = t1 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the divider.
	always_ff @(posedge clk) begin
		if (start) begin
			rem0_q <= '0;
			rem1_q <= '0;
			quo0_q <= num0;
			quo1_q <= num1;
			den_q <= den;
			neg0_q <= neg0;
			neg1_q <= neg1;
		end else if (busy_q) begin
			rem0_q <= ge0 ? 33'(t0 - {1'b0, den_q}) : t0[32:0];
			rem1_q <= ge1 ? 33'(t1 - {1'b0, den_q}) : t1[32:0];
			quo0_q <= {quo0_q[NUM_W-2:0], ge0};
			quo1_q <= {quo1_q[NUM_W-2:0], ge1};
		end
	end

	// Sign restore and saturation of a quotient magnitude.
	function automatic logic [31:0] fix(input logic [NUM_W-1:0] q, input logic neg);
		if (neg) begin
			fix = (q > NUM_W'(64'd2147483648)) ? 32'h8000_0000 : 32'(-q);
		end else begin
			fix = (q > NUM_W'(64'd2147483647)) ? 32'h7fff_ffff : q[31:0];
		end
	endfunction

	assign q0 = fix(quo0_q, neg0_q);
	assign q1 = fix(quo1_q, neg1_q);
	assign done = done_q;

	`KTAF_ASSERT_NXT(a_div_start_busy, start, busy_q && !done_q)
	`KTAF_ASSERT_IMP(a_div_done_idle, done_q, !busy_q)
	`KTAF_ASSERT_IMP(a_div_no_restart, busy_q, !start)
endmodule

>>> rtl/ktaf_datapath.sv
// Datapath: configuration, state banks, shared multiplier and divider.
module ktaf_datapath #(
	parameter int unsigned NUM_AXES = ktaf_pkg::NUM_AXES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ktaf_pkg::IDX_W-1:0] wr_index,
	input logic [ktaf_pkg::DATA_W-1:0] wr_data,
	input logic in_axis,
	input logic [31:0] in_accel,
	input logic [31:0] in_gyro,
	input ktaf_pkg::ktaf_cmd_t cmd,
	output ktaf_pkg::ktaf_sts_t sts,
	output logic out_axis,
	output logic [31:0] out_angle,
	output logic [31:0] out_rate,
	output logic [31:0] out_bias
);
	import ktaf_pkg::*;

	localparam int unsigned BW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	logic [31:0] dt_q, qa_q, qg_q, r_q;
	logic [31:0] ang_bank_q [NUM_AXES];
	logic [31:0] bias_bank_q [NUM_AXES];
	logic [31:0] p00_bank_q [NUM_AXES];
	logic [31:0] p01_bank_q [NUM_AXES];
	logic [31:0] p10_bank_q [NUM_AXES];
	logic [31:0] p11_bank_q [NUM_AXES];

	logic [BW-1:0] bank, bank_q;
	logic axis_q;
	logic [31:0] accel_q, gyro_q;
	logic [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic [31:0] rate_q, pd0_q, err_q, k0_q, k1_q;
	logic signed [39:0] e_q;
	logic signed [39:0] e_c;
	logic e_pos;
	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod_q;
	logic signed [65:0] prod_r;
	logic signed [39:0] rnd;
	logic [31:0] mag00, mag10;
	logic [31:0] dq0, dq1;

	assign bank = (NUM_AXES > 1) ? BW'(in_axis) : '0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RST;
			qa_q <= QA_RST;
			qg_q <= QG_RST;
			r_q <= R_RST;
		end else if (wr_en) begin
			unique case (ktaf_reg_t'(wr_index))
				REG_DT: dt_q <= wr_data;
				REG_QA: qa_q <= wr_data;
				REG_QG: qg_q <= wr_data;
				REG_R: r_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.op)
			OP_ANG: begin op_a = {rate_q[31], rate_q}; op_b = {1'b0, dt_q}; end
			OP_P00: begin op_a = {pd0_q[31], pd0_q}; op_b = {1'b0, dt_q}; end
			OP_P01: begin op_a = {p11_q[31], p11_q}; op_b = {1'b0, dt_q}; end
			OP_QG: begin op_a = {1'b0, qg_q}; op_b = {1'b0, dt_q}; end
			OP_C00: begin op_a = {k0_q[31], k0_q}; op_b = {p00_q[31], p00_q}; end
			OP_C01: begin op_a = {k0_q[31], k0_q}; op_b = {p01_q[31], p01_q}; end
			OP_C10: begin op_a = {k1_q[31], k1_q}; op_b = {p00_q[31], p00_q}; end
			OP_C11: begin op_a = {k1_q[31], k1_q}; op_b = {p01_q[31], p01_q}; end
			OP_ANGC: begin op_a = {k0_q[31], k0_q}; op_b = {err_q[31], err_q}; end
			OP_BIASC: begin op_a = {k1_q[31], k1_q}; op_b = {err_q[31], err_q}; end
			default: ;
		endcase
	end

	// Product rounded to nearest after the Q30 shift.
	assign prod_r = prod_q + (66'sd1 <<< 29);
	assign rnd = {{4{prod_r[65]}}, prod_r[65:30]};

	// Gain numerators as magnitudes; the divisor is formed from the predicted
	// covariance in the same cycle that the divider starts.
	assign mag00 = p00_q[31] ? 32'(-p00_q) : p00_q;
	assign mag10 = p10_q[31] ? 32'(-p10_q) : p10_q;
	assign e_c = {8'd0, r_q} + sx(p00_q);
	assign e_pos = !e_q[39] && (e_q != '0);

	ktaf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num0({mag00, 30'd0}),
		.num1({mag10, 30'd0}),
		.neg0(p00_q[31]),
		.neg1(p10_q[31]),
		.den(e_c[32:0]),
		.done(sts.div_done),
		.q0(dq0),
		.q1(dq1)
	);

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bank_q <= bank;
			axis_q <= in_axis;
			accel_q <= in_accel;
			gyro_q <= in_gyro;
			ang_q <= ang_bank_q[bank];
			bias_q <= bias_bank_q[bank];
			p00_q <= p00_bank_q[bank];
			p01_q <= p01_bank_q[bank];
			p10_q <= p10_bank_q[bank];
			p11_q <= p11_bank_q[bank];
		end
		if (cmd.pre) begin
			rate_q <= sat32(sx(gyro_q) - sx(bias_q));
			pd0_q <= sat32({8'd0, qa_q} - sx(p01_q) - sx(p10_q));
		end
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.wb_en) begin
			unique case (cmd.op)
				OP_ANG: ang_q <= sat32(sx(ang_q) + rnd);
				OP_P00: p00_q <= sat32(sx(p00_q) + rnd);
				OP_P01: begin
					p01_q <= sat32(sx(p01_q) - rnd);
					p10_q <= sat32(sx(p10_q) - rnd);
				end
				OP_QG: p11_q <= sat32(sx(p11_q) + rnd);
				OP_ANGC: ang_q <= sat32(sx(ang_q) + rnd);
				OP_BIASC: bias_q <= sat32(sx(bias_q) + rnd);
				default: ;
			endcase
		end
		if (cmd.setup) begin
			err_q <= sat32(sx(accel_q) - sx(ang_q));
			e_q <= e_c;
		end
		if (sts.div_done) begin
			k0_q <= e_pos ? dq0 : '0;
			k1_q <= e_pos ? dq1 : '0;
		end
		if (cmd.finish) begin
			out_axis <= axis_q;
			out_angle <= ang_q;
			out_rate <= sat32(sx(gyro_q) - sx(bias_q));
			out_bias <= bias_q;
		end
	end

	// State banks: posterior covariance per product, angle and bias at finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				ang_bank_q[i] <= '0;
				bias_bank_q[i] <= '0;
				p00_bank_q[i] <= ONE_Q30;
				p01_bank_q[i] <= '0;
				p10_bank_q[i] <= '0;
				p11_bank_q[i] <= ONE_Q30;
			end
		end else begin
			if (cmd.wb_en) begin
				unique case (cmd.op)
					OP_C00: p00_bank_q[bank_q] <= sat32(sx(p00_q) - rnd);
					OP_C01: p01_bank_q[bank_q] <= sat32(sx(p01_q) - rnd);
					OP_C10: p10_bank_q[bank_q] <= sat32(sx(p10_q) - rnd);
					OP_C11: p11_bank_q[bank_q] <= sat32(sx(p11_q) - rnd);
					default: ;
				endcase
			end
			if (cmd.finish) begin
				ang_bank_q[bank_q] <= ang_q;
				bias_bank_q[bank_q] <= bias_q;
			end
		end
	end
endmodule

>>> rtl/ktaf_ctrl.sv
// Controller: sequences load, predict, gain division, correction and result.
`include "assert_macros.svh"
module ktaf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input ktaf_pkg::ktaf_sts_t sts,
	output ktaf_pkg::ktaf_cmd_t cmd
);
	import ktaf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_MUL,
		S_WB,
		S_SETUP,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	ktaf_op_t op_q;
	logic out_valid_q;
	logic accept;
	logic finish;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign finish = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Commands decoded from the state.
	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.load = accept;
		cmd.pre = (state_q == S_PRE);
		cmd.mul_en = (state_q == S_MUL);
		cmd.wb_en = (state_q == S_WB);
		cmd.setup = (state_q == S_SETUP);
		cmd.div_start = (state_q == S_SETUP);
		cmd.finish = finish;
	end

	// Sequencer and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_ANG;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					op_q <= OP_ANG;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					priority if (op_q == OP_QG) begin
						state_q <= S_SETUP;
					end else if (op_q == OP_BIASC) begin
						state_q <= S_DONE;
					end else begin
						op_q <= ktaf_op_t'(op_q + 4'd1);
						state_q <= S_MUL;
					end
				end
				S_SETUP: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) begin
						op_q <= OP_C00;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`KTAF_ASSERT_NXT(a_finish_valid, finish, out_valid_q)
	`KTAF_ASSERT_IMP(a_done_in_div, sts.div_done, state_q == S_DIV)
	`KTAF_ASSERT_NXT(a_accept_pre, accept, state_q == S_PRE)
endmodule

>>> rtl/kalman_tilt_angle_filter.sv
// Each request runs through the 62-step divider and ten passes through the
// single shared multiplier; requests are taken only in the idle state, so
// the next is not accepted until the previous one has finished.
// A new request is taken while the previous result still waits.
// Reset (arst_n low) restores register defaults and resets the state banks
// at once; no clearing pass.
module kalman_tilt_angle_filter #(
	parameter int unsigned NUM_AXES = ktaf_pkg::NUM_AXES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [ktaf_pkg::IDX_W-1:0] wr_index,
	input logic [ktaf_pkg::DATA_W-1:0] wr_data,
	ktaf_in_if.sink sample,
	ktaf_out_if.source result
);
	import ktaf_pkg::*;

	ktaf_cmd_t cmd;
	ktaf_sts_t sts;
	logic out_axis;
	logic [31:0] out_angle, out_rate, out_bias;

	// Sequencer.
	ktaf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample.valid),
		.in_ready(sample.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.sts(sts),
		.cmd(cmd)
	);

	// Arithmetic and state.
	ktaf_datapath #(.NUM_AXES(NUM_AXES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_axis(sample.axis),
		.in_accel(sample.accel_angle),
		.in_gyro(sample.gyro_rate),
		.cmd(cmd),
		.sts(sts),
		.out_axis(out_axis),
		.out_angle(out_angle),
		.out_rate(out_rate),
		.out_bias(out_bias)
	);

	assign result.axis_out = out_axis;
	assign result.filtered_angle = out_angle;
	assign result.corrected_rate = out_rate;
	assign result.gyro_bias = out_bias;
endmodule
